>>> rtl/twtp_pkg.sv
// shared types, constants and character codes for the word tokenizer and packer
package twtp_pkg;

    localparam int DEF_MAX_WORD_BYTES = 30;
    localparam int DEF_KEPT_CHARS     = 15;

    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 6;
    localparam int TYPE_W     = 6;
    localparam int WORD_W     = 32;
    localparam int CODE_CHARS = 15;
    localparam int CODE_W     = TYPE_W + CODE_CHARS * CHAR_W;

    localparam logic [CHAR_W-1:0] CODE_DIGIT0 = 6'h1B;
    localparam logic [CHAR_W-1:0] CODE_USCORE = 6'h25;
    localparam logic [CHAR_W-1:0] CODE_DASH   = 6'h26;
    localparam logic [CHAR_W-1:0] CODE_BANG   = 6'h27;

    typedef logic [CHAR_W-1:0] t_char;

    typedef struct packed {
        logic  ws;       // c whitespace
        logic  alnum;    // letter or digit
        logic  wordy;    // letter, '_' or '-'
        logic  other;    // punctuation other than '_' and '-'
        t_char code;     // lowercased 6-bit character code
    } t_byte_class;

endpackage

>>> rtl/text_word_tokenize_pack.sv
// word tokenizer top level: input register, word tracker and packed-code result register
//
// text channel: one byte per beat on i_text_byte, i_text_last marks the final byte
// of a text. a beat is taken at a rising edge with i_text_valid high and
// o_text_stall low. code channel: one 96-bit packed word per beat on
// o_code_word0..2 (most significant first), taken when o_code_valid is high and
// i_code_stall is low. a code comes out only for the byte that closes an
// accepted word: the whitespace after it, or the byte flagged last.
// i_cfg_we writes the 6-bit field type from i_cfg_data; write it only while idle.
// a code passes two registers: the closing byte is taken into the input register, and
// the code loads into the result register once that register can take it, with
// classify, word tracking and packing between the two registers.
// throughput: one byte per cycle while the receiver takes codes; every byte passes
// the single result register, so a waiting code holds back all bytes.
// a stalled code holds the result register; the byte in the input register then
// waits and o_text_stall rises until the code is taken.
// reset (synchronous, active low) closes any open word, empties both registers
// and sets the field type to zero.
module text_word_tokenize_pack #(
    parameter int MAX_WORD_BYTES = twtp_pkg::DEF_MAX_WORD_BYTES,
    parameter int KEPT_CHARS     = twtp_pkg::DEF_KEPT_CHARS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [twtp_pkg::TYPE_W-1:0] i_cfg_data,
    input  logic                        i_text_valid,
    output logic                        o_text_stall,
    input  logic [twtp_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                        i_text_last,
    output logic                        o_code_valid,
    input  logic                        i_code_stall,
    output logic [twtp_pkg::WORD_W-1:0] o_code_word0,
    output logic [twtp_pkg::WORD_W-1:0] o_code_word1,
    output logic [twtp_pkg::WORD_W-1:0] o_code_word2
);
    import twtp_pkg::*;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic        adv;        // result register can take a new value
    logic        step;       // the held byte is processed this cycle
    logic        emit;
    t_byte_class cls;
    t_char       chars [CODE_CHARS];

    // a byte that closes no word still needs the result slot only to drop valid
    assign adv          = !o_code_valid || !i_code_stall;
    assign step         = r_in_valid && adv;
    assign o_text_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_text_stall) begin
            r_in_valid <= i_text_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text_valid && !o_text_stall) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_text_last;
        end
    end

    twtp_classify u_classify (
        .i_byte (r_in_byte),
        .o_cls  (cls)
    );

    twtp_word #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES),
        .KEPT_CHARS     (KEPT_CHARS)
    ) u_word (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_last  (r_in_last),
        .i_cls   (cls),
        .o_emit  (emit),
        .o_chars (chars)
    );

    // an empty input register moves a bubble into the result slot
    twtp_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_emit     (emit),
        .i_chars    (chars),
        .o_valid    (o_code_valid),
        .o_word0    (o_code_word0),
        .o_word1    (o_code_word1),
        .o_word2    (o_code_word2)
    );

endmodule

>>> rtl/twtp_classify.sv
// byte classifier: whitespace, alnum, wordy and punctuation flags plus the 6-bit code
module twtp_classify (
    input  logic [twtp_pkg::BYTE_W-1:0] i_byte,
    output twtp_pkg::t_byte_class       o_cls
);
    import twtp_pkg::*;

    logic is_lower;
    logic is_upper;
    logic is_digit;
    logic is_us;
    logic is_dash;
    logic [BYTE_W-1:0] off;

    always_comb begin
        is_lower = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
        is_upper = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
        is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        is_us    = (i_byte == 8'h5F);
        is_dash  = (i_byte == 8'h2D);
        off      = '0;

        o_cls.ws    = (i_byte == 8'h20) || ((i_byte >= 8'h09) && (i_byte <= 8'h0D));
        o_cls.alnum = is_lower || is_upper || is_digit;
        o_cls.wordy = is_lower || is_upper || is_us || is_dash;
        o_cls.other = !(is_lower || is_upper || is_digit || is_us || is_dash);

        if (is_lower) begin
            off        = i_byte - 8'h60;
            o_cls.code = off[CHAR_W-1:0];
        end else if (is_upper) begin
            off        = i_byte - 8'h40;
            o_cls.code = off[CHAR_W-1:0];
        end else if (is_digit) begin
            off        = i_byte - 8'h30;
            o_cls.code = CODE_DIGIT0 + off[CHAR_W-1:0];
        end else if (is_us) begin
            o_cls.code = CODE_USCORE;
        end else if (is_dash) begin
            o_cls.code = CODE_DASH;
        end else if (i_byte == 8'h21) begin
            o_cls.code = CODE_BANG;
        end else begin
            o_cls.code = i_byte[CHAR_W-1:0];
        end
    end

endmodule

>>> rtl/twtp_word.sv
// word tracker: open-word flags, byte count and the trimmed character buffer
module twtp_word #(
    parameter int MAX_WORD_BYTES = twtp_pkg::DEF_MAX_WORD_BYTES,
    parameter int KEPT_CHARS     = twtp_pkg::DEF_KEPT_CHARS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_last,
    input  twtp_pkg::t_byte_class i_cls,
    output logic                  o_emit,
    output twtp_pkg::t_char       o_chars [twtp_pkg::CODE_CHARS]
);
    import twtp_pkg::*;

    localparam int BCW = $clog2(MAX_WORD_BYTES + 2);
    localparam int SCW = $clog2(KEPT_CHARS + 1);
    localparam logic [BCW-1:0] MAX_CNT = BCW'(MAX_WORD_BYTES);
    localparam logic [SCW-1:0] KEPT_CNT = SCW'(KEPT_CHARS);

    logic [BCW-1:0] r_count, n_count, w_count;
    logic           r_in_word, n_in_word, w_in_word;
    logic           r_bad, n_bad, w_bad;
    logic           r_letter, n_letter, w_letter;
    logic           r_prev, n_prev, w_prev;
    logic           r_found, n_found, w_found;
    logic [SCW-1:0] r_span, n_span, w_span;
    logic [SCW-1:0] r_trim, n_trim, w_trim;
    t_char          r_chars [KEPT_CHARS];
    t_char          w_chars [KEPT_CHARS];

    logic           store;
    logic [SCW-1:0] pos;
    logic           closing;
    logic           ok;

    always_comb begin
        w_count   = r_count;
        w_in_word = r_in_word;
        w_bad     = r_bad;
        w_letter  = r_letter;
        w_prev    = r_prev;
        w_found   = r_found;
        w_span    = r_span;
        w_trim    = r_trim;
        store     = 1'b0;
        pos       = r_found ? r_span : '0;

        if (!i_cls.ws) begin
            w_bad     = r_bad | r_prev;
            w_in_word = 1'b1;
            if (r_count <= MAX_CNT) begin
                w_count = r_count + 1'b1;
            end
            w_letter = r_letter | i_cls.wordy;
            w_prev   = i_cls.other;
            // kept span starts at the first alphanumeric byte
            if (r_found || i_cls.alnum) begin
                store   = (pos < KEPT_CNT);
                w_span  = store ? pos + 1'b1 : pos;
                w_found = 1'b1;
                if (i_cls.alnum) begin
                    w_trim = w_span;
                end
            end
            if (i_last) begin
                w_bad = w_bad | w_prev;
            end
        end

        closing = i_cls.ws ? r_in_word : i_last;
        ok      = w_in_word && !w_bad && w_letter && (w_count <= MAX_CNT) && w_found;
        o_emit  = i_en && closing && ok;

        if (closing || i_cls.ws) begin
            n_count   = '0;
            n_in_word = 1'b0;
            n_bad     = 1'b0;
            n_letter  = 1'b0;
            n_prev    = 1'b0;
            n_found   = 1'b0;
            n_span    = '0;
            n_trim    = '0;
        end else begin
            n_count   = w_count;
            n_in_word = w_in_word;
            n_bad     = w_bad;
            n_letter  = w_letter;
            n_prev    = w_prev;
            n_found   = w_found;
            n_span    = w_span;
            n_trim    = w_trim;
        end
    end

    for (genvar k = 0; k < KEPT_CHARS; k++) begin : g_buf
        assign w_chars[k] = (store && (pos == SCW'(k))) ? i_cls.code : r_chars[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_chars[k] <= w_chars[k];
            end
        end
    end

    // characters past the last alphanumeric one read as zero
    for (genvar k = 0; k < CODE_CHARS; k++) begin : g_out
        if (k < KEPT_CHARS) begin : g_kept
            assign o_chars[k] = (SCW'(k) < w_trim) ? w_chars[k] : '0;
        end else begin : g_zero
            assign o_chars[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_in_word <= 1'b0;
            r_bad     <= 1'b0;
            r_letter  <= 1'b0;
            r_prev    <= 1'b0;
            r_found   <= 1'b0;
            r_span    <= '0;
            r_trim    <= '0;
        end else if (i_en) begin
            r_count   <= n_count;
            r_in_word <= n_in_word;
            r_bad     <= n_bad;
            r_letter  <= n_letter;
            r_prev    <= n_prev;
            r_found   <= n_found;
            r_span    <= n_span;
            r_trim    <= n_trim;
        end
    end

endmodule

>>> rtl/twtp_pack.sv
// field type register, 96-bit code packing and the result register
module twtp_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [twtp_pkg::TYPE_W-1:0]   i_cfg_data,
    input  logic                          i_adv,
    input  logic                          i_emit,
    input  twtp_pkg::t_char               i_chars [twtp_pkg::CODE_CHARS],
    output logic                          o_valid,
    output logic [twtp_pkg::WORD_W-1:0]   o_word0,
    output logic [twtp_pkg::WORD_W-1:0]   o_word1,
    output logic [twtp_pkg::WORD_W-1:0]   o_word2
);
    import twtp_pkg::*;

    logic [TYPE_W-1:0] r_type_num;
    logic              r_valid;
    logic [CODE_W-1:0] r_code, n_code;

    always_comb begin
        n_code = '0;
        n_code[CODE_W-1 -: TYPE_W] = r_type_num;
        for (int k = 0; k < CODE_CHARS; k++) begin
            n_code[CODE_W-TYPE_W-1-CHAR_W*k -: CHAR_W] = i_chars[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_num <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_type_num <= i_cfg_data;
            end
            if (i_adv) begin
                r_valid <= i_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_emit) begin
            r_code <= n_code;
        end
    end

    assign o_valid = r_valid;
    assign o_word0 = r_code[3*WORD_W-1 -: WORD_W];
    assign o_word1 = r_code[2*WORD_W-1 -: WORD_W];
    assign o_word2 = r_code[WORD_W-1:0];

endmodule

>>> tb/text_word_tokenize_pack_tb.sv
// self-checking testbench for the word tokenizer and 96-bit packer
module text_word_tokenize_pack_tb;
    import twtp_pkg::*;

    localparam int MAX_BYTES   = DEF_MAX_WORD_BYTES;
    localparam int KEEP_CHARS  = DEF_KEPT_CHARS;
    localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either channel
    localparam int DRAIN_WAIT  = 6;      // input reg + result reg, with margin

    // tracks the word being collected and holds the codes still owed by the block
    class word_code_tracker;
        logic [TYPE_W-1:0] type_num;
        logic [BYTE_W-1:0] word_buf [MAX_BYTES];
        int unsigned       byte_cnt;
        bit                in_word;
        bit                bad_punct;
        bit                letter_seen;
        bit                prev_other;
        logic [CODE_W-1:0] pending_codes [$];
        int unsigned       errors;

        function new();
            type_num = '0;
            errors   = 0;
            clear_word();
        endfunction

        function void clear_word();
            byte_cnt    = 0;
            in_word     = 0;
            bad_punct   = 0;
            letter_seen = 0;
            prev_other  = 0;
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit is_upper(logic [7:0] c);
            return c >= "A" && c <= "Z";
        endfunction

        function bit is_lower(logic [7:0] c);
            return c >= "a" && c <= "z";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function t_char char_code(logic [7:0] c);
            if (is_lower(c)) return t_char'(c - "a" + 1);
            if (is_digit(c)) return CODE_DIGIT0 + t_char'(c - "0");
            if (c == "_") return CODE_USCORE;
            if (c == "-") return CODE_DASH;
            if (c == "!") return CODE_BANG;
            return c[CHAR_W-1:0];
        endfunction

        // a word ends: decide acceptance, trim, lowercase, cut and pack
        function void close_word();
            int unsigned       n, first, lastpos;
            bit                found, ok, alnum;
            logic [CODE_W-1:0] code;
            logic [7:0]        c;
            n = (byte_cnt < MAX_BYTES) ? byte_cnt : MAX_BYTES;
            ok = in_word && !bad_punct && letter_seen && byte_cnt <= MAX_BYTES;
            found = 0;
            first = 0;
            lastpos = 0;
            for (int unsigned i = 0; i < n; i++) begin
                alnum = is_upper(word_buf[i]) || is_lower(word_buf[i]) || is_digit(word_buf[i]);
                if (alnum) begin
                    if (!found) first = i;
                    lastpos = i;
                    found = 1;
                end
            end
            clear_word();
            if (!ok || !found) return;
            code = '0;
            code[CODE_W-1 -: TYPE_W] = type_num;
            for (int unsigned k = 0; k < KEEP_CHARS && first + k <= lastpos; k++) begin
                c = word_buf[first + k];
                if (is_upper(c)) c = c + 8'h20;
                code[CODE_W-1-TYPE_W-CHAR_W*k -: CHAR_W] = char_code(c);
            end
            pending_codes.push_back(code);
        endfunction

        // one accepted text beat
        function void note_beat(logic [7:0] c, logic last);
            bit alnum;
            if (is_ws(c)) begin
                if (in_word) close_word();
                return;
            end
            alnum = is_upper(c) || is_lower(c) || is_digit(c);
            if (prev_other) bad_punct = 1;
            in_word = 1;
            if (byte_cnt < MAX_BYTES) word_buf[byte_cnt] = c;
            if (byte_cnt <= MAX_BYTES) byte_cnt++;
            if (is_upper(c) || is_lower(c) || c == "_" || c == "-") letter_seen = 1;
            prev_other = !alnum && c != "_" && c != "-";
            if (last) begin
                if (prev_other) bad_punct = 1;
                close_word();
            end
        endfunction

        // one accepted code beat
        function void check_code(logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                 logic [WORD_W-1:0] w2);
            logic [CODE_W-1:0] exp_code;
            if (pending_codes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected code beat: %h %h %h", w0, w1, w2);
                return;
            end
            exp_code = pending_codes.pop_front();
            if (w0 !== exp_code[95:64] || w1 !== exp_code[63:32] || w2 !== exp_code[31:0]) begin
                errors++;
                if (errors <= 10)
                    $display("code mismatch: expected %h %h %h, got %h %h %h",
                             exp_code[95:64], exp_code[63:32], exp_code[31:0], w0, w1, w2);
            end
        endfunction
    endclass

    // dut ports, inputs known from time zero
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [TYPE_W-1:0]   i_cfg_data   = '0;
    logic                i_text_valid = 1'b0;
    logic                o_text_stall;
    logic [BYTE_W-1:0]   i_text_byte  = '0;
    logic                i_text_last  = 1'b0;
    logic                o_code_valid;
    logic                i_code_stall = 1'b0;
    logic [WORD_W-1:0]   o_code_word0;
    logic [WORD_W-1:0]   o_code_word1;
    logic [WORD_W-1:0]   o_code_word2;

    word_code_tracker tracker = new();

    // idle and stall percentages for the current phase, and the watchdog counter
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned quiet_cycles  = 0;

    text_word_tokenize_pack i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_text_valid (i_text_valid),
        .o_text_stall (o_text_stall),
        .i_text_byte  (i_text_byte),
        .i_text_last  (i_text_last),
        .o_code_valid (o_code_valid),
        .i_code_stall (i_code_stall),
        .o_code_word0 (o_code_word0),
        .o_code_word1 (o_code_word1),
        .o_code_word2 (o_code_word2)
    );

    always #1 i_clk = ~i_clk;

    // receiver back-pressure, independent of o_code_valid
    always @(posedge i_clk) begin
        i_code_stall <= ($urandom_range(99) < stall_pct);
    end

    // beat monitor: values read here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_text_valid && !o_text_stall)
                tracker.note_beat(i_text_byte, i_text_last);
            if (o_code_valid && !i_code_stall)
                tracker.check_code(o_code_word0, o_code_word1, o_code_word2);
        end
    end

    // watchdog: a run with no beat for too long is hung
    always @(posedge i_clk) begin
        if ((i_text_valid && !o_text_stall) || (o_code_valid && !i_code_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one text beat, with a random gap in front of it; returns after acceptance
    task automatic send_text_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_text_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_text_valid <= 1'b1;
        i_text_byte  <= b;
        i_text_last  <= last;
        @(posedge i_clk);
        while (o_text_stall) @(posedge i_clk);
    endtask

    // a string, last flag on its final byte if asked
    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_text_beat(s[i], last_at_end && i == s.len() - 1);
    endtask

    // field type is only touched once every owed code is out and the pipe is empty
    task automatic write_type_reg(input logic [TYPE_W-1:0] v);
        i_text_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        tracker.type_num = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] ws_byte();
        int unsigned r;
        r = $urandom_range(5);
        return (r == 0) ? 8'h20 : 8'(8'h08 + r);
    endfunction

    function automatic logic [7:0] punct_byte();
        string p = "\"'(.,;:!?)[]*/#";
        return p[$urandom_range(p.len() - 1)];
    endfunction

    // letters mostly, digits, mixed case, underscore and dash
    function automatic logic [7:0] body_byte();
        case ($urandom_range(9))
            4, 5:    return 8'("A" + $urandom_range(25));
            6, 7:    return 8'("0" + $urandom_range(9));
            8:       return $urandom_range(1) ? 8'h5F : 8'h2D;
            default: return 8'("a" + $urandom_range(25));
        endcase
    endfunction

    // random text: mostly plausible words, some noise and some broken words
    task automatic send_random_text(input int unsigned n_items);
        logic [7:0]  word_q [$];
        int unsigned sent, iter, len, kind;
        bit          end_text;
        sent = 0;
        iter = 0;
        while (sent < n_items) begin
            word_q.delete();
            // the first two words sit right at and just past the length limit
            if (iter == 0)
                len = MAX_BYTES;
            else if (iter == 1)
                len = MAX_BYTES + 1;
            else
                len = ($urandom_range(9) == 0) ? $urandom_range(11, 34) : $urandom_range(1, 10);
            kind = (iter < 2) ? 0 : $urandom_range(99);
            if (kind < 70) begin
                if ($urandom_range(9) == 0) word_q.push_back(punct_byte());
                repeat (len) word_q.push_back(body_byte());
                if ($urandom_range(5) == 0) word_q.push_back(punct_byte());
            end else if (kind < 85) begin
                repeat (len) word_q.push_back(8'($urandom_range(255)));
            end else begin
                // punctuation inside the word, followed by a word byte
                repeat (len + 1) word_q.push_back(body_byte());
                word_q.insert($urandom_range(word_q.size() - 2), punct_byte());
            end
            end_text = ($urandom_range(19) == 0);
            foreach (word_q[i])
                send_text_beat(word_q[i], end_text && i == word_q.size() - 1);
            sent += word_q.size();
            if (!end_text) begin
                repeat ($urandom_range(1, 2))
                    send_text_beat(ws_byte(), $urandom_range(29) == 0);
                sent++;
            end
            iter++;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, field type at its reset value
        send_text("A", 1);                  // one-letter word closed by the last flag
        send_text(" \t", 0);                // whitespace with no word open
        send_text("-x! ", 0);               // punctuation trimmed at both ends
        send_text("9", 0);                  // digits only: no letter, rejected
        send_text_beat(8'h0A, 1'b0);
        send_text_beat(8'h00, 1'b0);        // zero byte is plain punctuation
        send_text_beat(8'h0D, 1'b0);
        send_text("a!b", 0);                // punctuation not followed by whitespace
        send_text_beat(8'h0B, 1'b0);
        send_text_beat(8'hFF, 1'b0);        // high byte, then letter ending the text
        send_text("Q", 1);
        send_text("Zz_0", 0);               // upper case folded, underscore kept
        send_text_beat(8'h0C, 1'b0);
        send_text("k?", 1);                 // punctuation at end of text rejects

        // random phases, each with its own field type and idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_type_reg(6'h3F);
                1: write_type_reg(6'h00);
                default: write_type_reg(TYPE_W'($urandom_range(1, 62)));
            endcase
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            send_random_text(150);
            send_text("z", 1);              // closes whatever word is open
        end

        // drain, then let the pipe settle
        i_text_valid <= 1'b0;
        while (tracker.pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT + 2) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_codes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/twtp_pkg.sv
rtl/twtp_classify.sv
rtl/twtp_word.sv
rtl/twtp_pack.sv
rtl/text_word_tokenize_pack.sv
tb/text_word_tokenize_pack_tb.sv
